// ----- rtl/lcdseq_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and tables for the character LCD bus sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  // Request codes carried in the cmd field.
  localparam logic [2:0] CMD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_CHAR   = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_INIT   = 3'd4;

  // Display commands used by the clear and cursor requests.
  localparam logic [7:0] LCD_CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] LCD_RETURN_HOME   = 8'h02;
  localparam logic [7:0] ROW1_BASE         = 8'h80;
  localparam logic [7:0] ROW2_BASE         = 8'hC0;
  localparam logic [7:0] ROW3_BASE         = 8'h94;
  localparam logic [7:0] ROW4_BASE         = 8'hD4;

  // Queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Index of the last init command in each bus mode.
  localparam logic [2:0] INIT_LAST_8BIT = 3'd6;
  localparam logic [2:0] INIT_LAST_4BIT = 3'd7;

  // Input and output words.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] byte_value;
    logic [2:0] row;
    logic [5:0] column;
  } in_word_t;

  typedef struct packed {
    logic        reg_select;
    logic [7:0]  bus_value;
    logic [15:0] wait_before_us;
    logic        last;
  } out_word_t;

  // Classified job handed from the front end to the back end.
  typedef enum logic [1:0] {
    JOB_BYTE,
    JOB_CLEAR,
    JOB_INIT
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] value;
  } job_t;

  // Power-up init command bytes.
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0, 3'd1, 3'd2: b = 8'h38;
      3'd3:             b = 8'h02;
      3'd4:             b = 8'h0C;
      3'd5:             b = 8'h01;
      3'd6:             b = 8'h06;
      default:          b = 8'h28;
    endcase
    return b;
  endfunction

  // Wait in microseconds before the first transfer of each init command.
  function automatic logic [15:0] init_wait(input logic [2:0] idx);
    logic [15:0] w;
    case (idx)
      3'd0:    w = 16'd40000;
      3'd1:    w = 16'd5000;
      3'd2:    w = 16'd150;
      3'd6:    w = 16'd2000;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/lcdseq_front.sv -----
// ----------------------------------------------------------------------------
// lcdseq_front
// Accepts request words, classifies them into jobs and computes the cursor
// address. Requests that produce no transfers are dropped here.
// ----------------------------------------------------------------------------
module lcdseq_front (
  input  lcdseq_pkg::in_word_t in_word,
  input  logic                 in_accept,
  output logic                 push,
  output lcdseq_pkg::job_t     push_job
);

  logic [7:0] row_base;
  logic       row_ok;

  // Row base address for cursor placement.
  always_comb begin
    row_ok   = 1'b1;
    row_base = lcdseq_pkg::ROW1_BASE;
    unique case (in_word.row)
      3'd1:    row_base = lcdseq_pkg::ROW1_BASE;
      3'd2:    row_base = lcdseq_pkg::ROW2_BASE;
      3'd3:    row_base = lcdseq_pkg::ROW3_BASE;
      3'd4:    row_base = lcdseq_pkg::ROW4_BASE;
      default: row_ok   = 1'b0;
    endcase
  end

  // Decode the request into a job.
  always_comb begin
    push           = 1'b0;
    push_job.kind  = lcdseq_pkg::JOB_BYTE;
    push_job.rs    = 1'b0;
    push_job.value = in_word.byte_value;
    unique case (in_word.cmd)
      lcdseq_pkg::CMD_BYTE: begin
        push = in_accept;
      end
      lcdseq_pkg::CMD_CHAR: begin
        push        = in_accept;
        push_job.rs = 1'b1;
      end
      lcdseq_pkg::CMD_CURSOR: begin
        push           = in_accept && row_ok;
        push_job.value = row_base + {2'b00, in_word.column} + 8'hFF;
      end
      lcdseq_pkg::CMD_CLEAR: begin
        push          = in_accept;
        push_job.kind = lcdseq_pkg::JOB_CLEAR;
      end
      lcdseq_pkg::CMD_INIT: begin
        push          = in_accept;
        push_job.kind = lcdseq_pkg::JOB_INIT;
      end
      default: push = 1'b0;
    endcase
  end

endmodule

// ----- rtl/lcdseq_queue.sv -----
// ----------------------------------------------------------------------------
// lcdseq_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lcdseq_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lcdseq_pkg::job_t push_job,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output lcdseq_pkg::job_t head_job
);

  lcdseq_pkg::job_t                    slot_r [lcdseq_pkg::QUEUE_DEPTH];
  logic [lcdseq_pkg::QUEUE_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [lcdseq_pkg::QUEUE_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [lcdseq_pkg::QUEUE_CW-1:0]     count_r, count_nxt;

  assign full       = (count_r == lcdseq_pkg::QUEUE_CW'(lcdseq_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // The front end must stall rather than overfill the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("job queue overflow");

  // The back end only retires a job that is present.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job queue underflow");

endmodule

// ----- rtl/lcdseq_back.sv -----
// ----------------------------------------------------------------------------
// lcdseq_back
// Expands the job at the head of the queue into enable-strobed transfers,
// one per cycle while out_stall is low, into an output register.
// ----------------------------------------------------------------------------
module lcdseq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  eight_bit_bus,
  input  logic                  head_valid,
  input  lcdseq_pkg::job_t      head_job,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lcdseq_pkg::out_word_t out_word
);

  logic [2:0]            idx_r, idx_nxt;
  logic                  nib_r, nib_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lcdseq_pkg::out_word_t out_word_r;
  lcdseq_pkg::out_word_t xfer;
  logic [7:0]            cur_byte;
  logic                  last_byte;
  logic                  load;

  // Byte of the current job at the current index.
  always_comb begin
    cur_byte  = head_job.value;
    last_byte = 1'b1;
    unique case (head_job.kind)
      lcdseq_pkg::JOB_BYTE: begin
        cur_byte  = head_job.value;
        last_byte = 1'b1;
      end
      lcdseq_pkg::JOB_CLEAR: begin
        cur_byte  = (idx_r == 3'd0) ? lcdseq_pkg::LCD_CLEAR_DISPLAY
                                    : lcdseq_pkg::LCD_RETURN_HOME;
        last_byte = (idx_r == 3'd1);
      end
      lcdseq_pkg::JOB_INIT: begin
        cur_byte  = lcdseq_pkg::init_byte(idx_r);
        last_byte = eight_bit_bus ? (idx_r == lcdseq_pkg::INIT_LAST_8BIT)
                                  : (idx_r == lcdseq_pkg::INIT_LAST_4BIT);
      end
      default: begin
        cur_byte  = head_job.value;
        last_byte = 1'b1;
      end
    endcase
  end

  // Transfer word: whole byte, or high nibble then low nibble.
  always_comb begin
    xfer.reg_select     = head_job.rs;
    xfer.wait_before_us = (head_job.kind == lcdseq_pkg::JOB_INIT && !nib_r)
                          ? lcdseq_pkg::init_wait(idx_r) : 16'd0;
    if (eight_bit_bus) begin
      xfer.bus_value = cur_byte;
    end else if (nib_r) begin
      xfer.bus_value = {4'h0, cur_byte[3:0]};
    end else begin
      xfer.bus_value = {4'h0, cur_byte[7:4]};
    end
    xfer.last = last_byte && (eight_bit_bus || nib_r);
  end

  // A transfer is loaded whenever a job is waiting and the output register is free or draining.
  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && xfer.last;

  always_comb begin
    idx_nxt       = idx_r;
    nib_nxt       = nib_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (xfer.last) begin
        idx_nxt = 3'd0;
        nib_nxt = 1'b0;
      end else if (eight_bit_bus || nib_r) begin
        idx_nxt = idx_r + 3'd1;
        nib_nxt = 1'b0;
      end else begin
        nib_nxt = 1'b1;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      nib_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      nib_r       <= nib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= xfer;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A new word appears only through a load.
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(load))
    else $error("output word appeared without a load");

  // A job never reaches its end while still on its high nibble in 4-bit mode.
  a_last_on_low_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    (load && xfer.last && !eight_bit_bus) |-> nib_r)
    else $error("job finished on a high nibble");

endmodule

// ----- rtl/char_lcd_bus_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer
// Turns LCD requests into runs of enable-strobed bus transfers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request word per handshake (in_valid high, in_stall low).
//            Requests are raw command, character, cursor placement, clear
//            and power-up init. Unknown rows and unused codes emit nothing.
//   out_*  : one transfer word per handshake (out_valid high, out_stall
//            low), carrying RS, the bus pins, the wait before the strobe and
//            a last flag on the final transfer of each request.
//   cfg_*  : writes the bus mode (1 for 8-bit, 0 for 4-bit); always ready.
// Path: a request is written into the job queue, and its first transfer word is
//   loaded from the queue head into the output register. Throughput: one
//   transfer per cycle while out_stall is low, set by the back-end expander;
//   a request expands into 1 to 16 transfers (4-bit init is the longest).
//   A two-entry job queue lets the next request be taken while the current
//   one is still being expanded.
// Reset: synchronous and active low; the queue empties, the output goes
//   invalid and the bus mode returns to 4-bit.
// Stall: out_stall holds the output word; the queue then fills and in_stall
//   rises once both entries are occupied.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lcdseq_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lcdseq_pkg::out_word_t out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  logic             eight_bit_bus_r;
  logic             in_accept;
  logic             push;
  lcdseq_pkg::job_t push_job;
  logic             pop;
  logic             full;
  logic             head_valid;
  lcdseq_pkg::job_t head_job;

  // Bus mode register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eight_bit_bus_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      eight_bit_bus_r <= cfg_data;
    end
  end

  // Input handshake.
  assign in_stall  = full;
  assign in_accept = in_valid && !in_stall;

  lcdseq_front u_front (
    .in_word   (in_word),
    .in_accept (in_accept),
    .push      (push),
    .push_job  (push_job)
  );

  lcdseq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  lcdseq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .eight_bit_bus (eight_bit_bus_r),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word)
  );

endmodule
